>>> hw/rtl/wsp_pkg.sv
// Package for the WAV stream parser: word types, phase and result codes,
// tag constants and shared limits. No dependencies.
`default_nettype none
package wsp_pkg;

    localparam int unsigned MAX_SAMPLE_BYTES = 4;
    localparam int unsigned MAX_CHANNELS     = 2;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [31:0] FMT_SIZE = 32'd16;

    typedef enum logic [3:0] {
        PH_RIFF   = 4'd0,
        PH_RSIZE  = 4'd1,
        PH_WAVE   = 4'd2,
        PH_ID     = 4'd3,
        PH_SKSIZE = 4'd4,
        PH_SKIP   = 4'd5,
        PH_FSIZE  = 4'd6,
        PH_FBODY  = 4'd7,
        PH_DTAG   = 4'd8,
        PH_DSIZE  = 4'd9,
        PH_SAMP   = 4'd10,
        PH_DRAIN  = 4'd11,
        PH_DONE   = 4'd12,
        PH_ERR    = 4'd13
    } t_phase;

    typedef enum logic [1:0] {
        K_SAMPLE = 2'd0,
        K_FORMAT = 2'd1,
        K_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        E_NONE      = 4'd0,
        E_NO_RIFF   = 4'd1,
        E_NO_WAVE   = 4'd2,
        E_NO_FMT    = 4'd3,
        E_FMT_SIZE  = 4'd4,
        E_TYPE      = 4'd5,
        E_BITS      = 4'd6,
        E_UNSUP     = 4'd7,
        E_NO_DATA   = 4'd8,
        E_EMPTY     = 4'd9,
        E_TRUNC     = 4'd10
    } t_err;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       stream_end;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sample;
        logic        channel;
        logic        end_of_data;
        logic [1:0]  channel_count;
        logic [31:0] sample_rate;
        logic [5:0]  bits_per_sample;
        logic [3:0]  error_code;
        logic        last_result;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic   step;
        logic   clear;
        t_phase phase;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic field_done;
        logic is_riff;
        logic is_wave;
        logic is_fmt;
        logic is_data;
        logic size_zero;
        logic size_is16;
        logic size_ge_ba;
        logic rem_last;
        t_err body_err;
        logic samp_done;
        logic eod;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> hw/rtl/wsp_if.sv
// Stream interfaces for the WAV stream parser: byte input and result output.
// Depends on wsp_pkg.
`default_nettype none
interface wsp_in_if import wsp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wsp_out_if import wsp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/wsp_datapath.sv
// Datapath of the WAV stream parser: field collection, format registers,
// sample assembly, frame credit and the latched result payload. Uses wsp_pkg.
`default_nettype none
module wsp_datapath import wsp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    input  wire logic [7:0]  i_byte,
    output t_dp_stat         o_stat,
    output logic [31:0]      o_sample,
    output logic             o_channel,
    output logic             o_eod,
    output logic [1:0]       o_chan_count,
    output logic [31:0]      o_rate,
    output logic [5:0]       o_bits
);

    logic [31:0] r_tag, n_tag;
    logic [1:0]  r_fbc, n_fbc;
    logic [31:0] r_size, n_size;
    logic [31:0] r_rem, n_rem;
    logic [15:0] r_type, n_type;
    logic [15:0] r_chans, n_chans;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_ba, n_ba;
    logic [15:0] r_bits, n_bits;
    logic [2:0]  r_sb, n_sb;
    logic [31:0] r_asm, n_asm;
    logic [1:0]  r_sbi, n_sbi;
    logic        r_ch, n_ch;
    logic [31:0] r_credit, n_credit;
    logic        r_last_frame, n_last_frame;

    logic [31:0] r_o_sample;
    logic        r_o_channel, r_o_eod;
    logic [1:0]  r_o_cc;
    logic [31:0] r_o_rate;
    logic [5:0]  r_o_bits;

    logic [31:0] tag_next, size_next, asm_next, samp_val, ba32, sub_a, diff;
    logic [15:0] bits_next, sb_calc;
    logic [3:0]  off;
    logic [5:0]  sh;
    logic        last_ch, diff_lt;

    // Field assembly and checks
    always_comb begin
        tag_next  = {r_tag[23:0], i_byte};
        size_next = (r_fbc == 2'd0) ? {24'd0, i_byte}
                                    : (r_size | ({24'd0, i_byte} << {r_fbc, 3'b000}));
        off       = 4'd0 - r_rem[3:0];
        bits_next = {i_byte, r_bits[7:0]};
        sb_calc   = (r_chans == 16'd2) ? {1'b0, r_ba[15:1]} : r_ba;
        ba32      = {16'd0, r_ba};
        sub_a     = (i_cmd.phase == PH_DSIZE) ? size_next : r_credit;
        diff      = sub_a - ba32;
        diff_lt   = diff < ba32;
        asm_next  = r_asm | ({24'd0, i_byte} << {r_sbi, 3'b000});
        sh        = 6'd32 - {r_sb, 3'b000};
        samp_val  = asm_next << sh[4:0];
        if (r_sb == 3'd1) begin
            samp_val[31] = ~samp_val[31];
        end
        last_ch   = (r_ch == (r_chans == 16'd2));
    end

    // Status for the controller
    always_comb begin
        o_stat.field_done = (r_fbc == 2'd3);
        o_stat.is_riff    = (tag_next == TAG_RIFF);
        o_stat.is_wave    = (tag_next == TAG_WAVE);
        o_stat.is_fmt     = (tag_next == TAG_FMT);
        o_stat.is_data    = (tag_next == TAG_DATA);
        o_stat.size_zero  = (size_next == 32'd0);
        o_stat.size_is16  = (size_next == FMT_SIZE);
        o_stat.size_ge_ba = (size_next >= ba32);
        o_stat.rem_last   = (r_rem <= 32'd1);
        o_stat.samp_done  = ({1'b0, r_sbi} + 3'd1) >= r_sb;
        o_stat.eod        = r_last_frame && last_ch;
        if (r_type != 16'd1) begin
            o_stat.body_err = E_TYPE;
        end else if (bits_next[2:0] != 3'd0) begin
            o_stat.body_err = E_BITS;
        end else if (r_chans < 16'd1 || r_chans > 16'(MAX_CHANNELS) ||
                     sb_calc < 16'd1 || sb_calc > 16'(MAX_SAMPLE_BYTES) ||
                     bits_next > 16'(8 * MAX_SAMPLE_BYTES)) begin
            o_stat.body_err = E_UNSUP;
        end else begin
            o_stat.body_err = E_NONE;
        end
    end

    // Next state of the parse registers
    always_comb begin
        n_tag = r_tag;  n_fbc = r_fbc;  n_size = r_size;  n_rem = r_rem;
        n_type = r_type; n_chans = r_chans; n_rate = r_rate; n_ba = r_ba;
        n_bits = r_bits; n_sb = r_sb; n_asm = r_asm; n_sbi = r_sbi; n_ch = r_ch;
        n_credit = r_credit; n_last_frame = r_last_frame;
        case (i_cmd.phase)
            PH_RIFF, PH_WAVE, PH_ID, PH_DTAG: begin
                n_tag = tag_next;
                n_fbc = r_fbc + 2'd1;
            end
            PH_RSIZE, PH_SKSIZE, PH_FSIZE, PH_DSIZE: begin
                n_size = size_next;
                n_fbc  = r_fbc + 2'd1;
                if (r_fbc == 2'd3) begin
                    n_rem = (i_cmd.phase == PH_FSIZE) ? FMT_SIZE : size_next;
                    if (i_cmd.phase == PH_DSIZE) begin
                        n_asm        = 32'd0;
                        n_sbi        = 2'd0;
                        n_ch         = 1'b0;
                        n_credit     = diff;
                        n_last_frame = diff_lt;
                    end
                end
            end
            PH_SKIP, PH_DRAIN: begin
                if (r_rem != 32'd0) n_rem = r_rem - 32'd1;
            end
            PH_FBODY: begin
                case (off)
                    4'd0:  n_type[7:0]   = i_byte;
                    4'd1:  n_type[15:8]  = i_byte;
                    4'd2:  n_chans[7:0]  = i_byte;
                    4'd3:  n_chans[15:8] = i_byte;
                    4'd4:  n_rate[7:0]   = i_byte;
                    4'd5:  n_rate[15:8]  = i_byte;
                    4'd6:  n_rate[23:16] = i_byte;
                    4'd7:  n_rate[31:24] = i_byte;
                    4'd12: n_ba[7:0]     = i_byte;
                    4'd13: n_ba[15:8]    = i_byte;
                    4'd14: n_bits[7:0]   = i_byte;
                    4'd15: n_bits[15:8]  = i_byte;
                    default: ;
                endcase
                if (r_rem != 32'd0) n_rem = r_rem - 32'd1;
                n_sb = sb_calc[2:0];
            end
            PH_SAMP: begin
                if (r_rem != 32'd0) n_rem = r_rem - 32'd1;
                if (o_stat.samp_done) begin
                    n_asm = 32'd0;
                    n_sbi = 2'd0;
                    n_ch  = (r_chans == 16'd2) ? ~r_ch : 1'b0;
                    // open the next frame
                    if (last_ch && !r_last_frame) begin
                        n_credit     = diff;
                        n_last_frame = diff_lt;
                    end
                end else begin
                    n_asm = asm_next;
                    n_sbi = r_sbi + 2'd1;
                end
            end
            default: ;
        endcase
    end

    // Hold parse registers; clear at reset and at end of file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.step && i_cmd.clear)) begin
            r_tag <= '0; r_fbc <= '0; r_size <= '0; r_rem <= '0;
            r_type <= '0; r_chans <= '0; r_rate <= '0; r_ba <= '0;
            r_bits <= '0; r_sb <= '0; r_asm <= '0; r_sbi <= '0; r_ch <= 1'b0;
            r_credit <= '0; r_last_frame <= 1'b0;
        end else if (i_cmd.step) begin
            r_tag <= n_tag; r_fbc <= n_fbc; r_size <= n_size; r_rem <= n_rem;
            r_type <= n_type; r_chans <= n_chans; r_rate <= n_rate; r_ba <= n_ba;
            r_bits <= n_bits; r_sb <= n_sb; r_asm <= n_asm; r_sbi <= n_sbi;
            r_ch <= n_ch; r_credit <= n_credit; r_last_frame <= n_last_frame;
        end
    end

    // Latch result payload for each word
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_o_sample  <= samp_val;
            r_o_channel <= r_ch;
            r_o_eod     <= o_stat.eod;
            r_o_cc      <= r_chans[1:0];
            r_o_rate    <= r_rate;
            r_o_bits    <= r_bits[5:0];
        end
    end

    assign o_sample     = r_o_sample;
    assign o_channel    = r_o_channel;
    assign o_eod        = r_o_eod;
    assign o_chan_count = r_o_cc;
    assign o_rate       = r_o_rate;
    assign o_bits       = r_o_bits;

endmodule
`default_nettype wire

>>> hw/rtl/wsp_ctrl.sv
// Controller of the WAV stream parser: phase state machine, result queue
// and handshakes. Uses wsp_pkg.
`default_nettype none
module wsp_ctrl import wsp_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_end,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_kind         o_kind,
    output t_err          o_code,
    output logic          o_from_a,
    output logic          o_last
);

    t_phase r_phase, n_phase, p_next;
    logic   r_a_valid, n_a_valid, r_b_valid, n_b_valid;
    t_kind  r_a_kind, n_a_kind;
    t_err   r_a_code, n_a_code, err;
    logic   step, res_a;
    t_kind  res_kind;

    assign o_in_ready = !r_a_valid && !r_b_valid;
    assign step       = i_in_valid && o_in_ready;

    // Next phase and first result of this word
    always_comb begin
        p_next   = r_phase;
        err      = E_NONE;
        res_a    = 1'b0;
        res_kind = K_SAMPLE;
        unique case (r_phase)
            PH_RIFF: if (i_stat.field_done) begin
                if (i_stat.is_riff) p_next = PH_RSIZE; else err = E_NO_RIFF;
            end
            PH_RSIZE: if (i_stat.field_done) p_next = PH_WAVE;
            PH_WAVE: if (i_stat.field_done) begin
                if (i_stat.is_wave) p_next = PH_ID; else err = E_NO_WAVE;
            end
            PH_ID: if (i_stat.field_done) begin
                p_next = i_stat.is_fmt ? PH_FSIZE : PH_SKSIZE;
            end
            PH_SKSIZE: if (i_stat.field_done) begin
                if (i_stat.size_zero) err = E_NO_FMT; else p_next = PH_SKIP;
            end
            PH_SKIP: if (i_stat.rem_last) p_next = PH_ID;
            PH_FSIZE: if (i_stat.field_done) begin
                if (i_stat.size_is16) p_next = PH_FBODY; else err = E_FMT_SIZE;
            end
            PH_FBODY: if (i_stat.rem_last) begin
                if (i_stat.body_err != E_NONE) err = i_stat.body_err;
                else p_next = PH_DTAG;
            end
            PH_DTAG: if (i_stat.field_done) begin
                if (i_stat.is_data) p_next = PH_DSIZE; else err = E_NO_DATA;
            end
            PH_DSIZE: if (i_stat.field_done) begin
                if (i_stat.size_zero) begin
                    err = E_EMPTY;
                end else begin
                    res_a    = 1'b1;
                    res_kind = K_FORMAT;
                    p_next   = i_stat.size_ge_ba ? PH_SAMP : PH_DRAIN;
                end
            end
            PH_SAMP: if (i_stat.samp_done) begin
                res_a    = 1'b1;
                res_kind = K_SAMPLE;
                if (i_stat.eod) p_next = i_stat.rem_last ? PH_DONE : PH_DRAIN;
            end
            PH_DRAIN: if (i_stat.rem_last) p_next = PH_DONE;
            PH_DONE:  p_next = PH_DONE;
            PH_ERR:   p_next = PH_ERR;
            default:  p_next = PH_ERR;
        endcase
        if (err != E_NONE) begin
            res_a    = 1'b1;
            res_kind = K_ERROR;
            p_next   = PH_ERR;
        end
    end

    // Phase register update and result queue
    always_comb begin
        n_phase   = r_phase;
        n_a_valid = r_a_valid;
        n_b_valid = r_b_valid;
        n_a_kind  = r_a_kind;
        n_a_code  = r_a_code;
        if (o_out_valid && i_out_ready) begin
            if (r_a_valid) n_a_valid = 1'b0; else n_b_valid = 1'b0;
        end
        if (step) begin
            n_a_valid = res_a;
            n_a_kind  = res_kind;
            n_a_code  = err;
            n_b_valid = i_end && (p_next != PH_DONE) && (p_next != PH_ERR);
            n_phase   = i_end ? PH_RIFF : p_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_RIFF;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_a_kind  <= K_SAMPLE;
            r_a_code  <= E_NONE;
        end else begin
            r_phase   <= n_phase;
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
            r_a_kind  <= n_a_kind;
            r_a_code  <= n_a_code;
        end
    end

    // Drive datapath commands and output word select
    always_comb begin
        o_cmd.step  = step;
        o_cmd.clear = i_end;
        o_cmd.phase = r_phase;
        o_out_valid = r_a_valid || r_b_valid;
        o_from_a    = r_a_valid;
        o_kind      = r_a_valid ? r_a_kind : K_ERROR;
        o_code      = r_a_valid ? r_a_code : E_TRUNC;
        o_last      = r_a_valid ? !r_b_valid : 1'b1;
    end

endmodule
`default_nettype wire

>>> hw/rtl/wav_stream_parser_top.sv
// WAV stream parser top level. Throughput: one byte per cycle while a byte
// makes no result; after a byte that makes results the input holds off until
// its one or two result words are taken. A result word is valid the cycle
// after its byte is accepted. Synchronous active-low reset returns the parser
// to the RIFF tag search with the result queue empty.
// Depends on wsp_pkg, wsp_if, wsp_ctrl and wsp_datapath.
`default_nettype none
module wav_stream_parser_top import wsp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wsp_in_if.sink     i_in,
    wsp_out_if.source  o_out
);

    t_dp_cmd     cmd;
    t_dp_stat    stat;
    t_kind       kind;
    t_err        code;
    logic        from_a, last;
    logic [31:0] dp_sample, dp_rate;
    logic        dp_channel, dp_eod;
    logic [1:0]  dp_cc;
    logic [5:0]  dp_bits;
    logic        in_ready, out_valid;

    wsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_end       (i_in.data.stream_end),
        .o_in_ready  (in_ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_kind      (kind),
        .o_code      (code),
        .o_from_a    (from_a),
        .o_last      (last)
    );

    wsp_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_byte       (i_in.data.byte_in),
        .o_stat       (stat),
        .o_sample     (dp_sample),
        .o_channel    (dp_channel),
        .o_eod        (dp_eod),
        .o_chan_count (dp_cc),
        .o_rate       (dp_rate),
        .o_bits       (dp_bits)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    // Zero the fields that do not belong to the word's kind
    always_comb begin
        o_out.data                 = '0;
        o_out.data.kind            = kind;
        o_out.data.last_result     = last;
        case (kind)
            K_SAMPLE: begin
                o_out.data.sample      = dp_sample;
                o_out.data.channel     = dp_channel;
                o_out.data.end_of_data = dp_eod;
            end
            K_FORMAT: begin
                o_out.data.channel_count   = dp_cc;
                o_out.data.sample_rate     = dp_rate;
                o_out.data.bits_per_sample = dp_bits;
            end
            default: begin
                o_out.data.error_code = from_a ? code : E_TRUNC;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> dv/tb_wav_stream_parser_top.sv
// Testbench for wav_stream_parser_top: drives WAV byte streams and checks result words
// against a cycle-free predictor of the parser. Depends on wsp_pkg, wsp_if and the RTL.
`timescale 1ns / 1ps
module tb_wav_stream_parser_top;
    import wsp_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    wsp_in_if  in_if ();
    wsp_out_if out_if ();

    wav_stream_parser_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state of the parser
    t_phase      pr_phase;
    logic [31:0] pr_tag, pr_size, pr_rem, pr_type, pr_ch, pr_rate, pr_ba, pr_bits;
    logic [31:0] pr_asm, pr_fcnt, pr_sidx, pr_cur;
    logic [63:0] pr_left;

    t_out_word expected_words[$];
    t_out_word step_words[$];
    byte unsigned wav_bytes[$];

    int mismatches = 0;
    int words_checked = 0;
    int bytes_sent = 0;
    int files_sent = 0;
    bit idle_on = 1'b1;
    bit long_hold = 1'b0;

    function automatic void parser_clear();
        pr_phase = PH_RIFF;
        {pr_tag, pr_size, pr_rem, pr_type, pr_ch, pr_rate, pr_ba, pr_bits} = '0;
        {pr_asm, pr_fcnt, pr_sidx, pr_cur} = '0;
        pr_left = '0;
    endfunction

    function automatic void add_word(t_kind k, logic [31:0] smp, logic ch, logic eod,
                                     logic [1:0] cc, logic [31:0] rate, logic [5:0] bits,
                                     t_err code);
        t_out_word w;
        w = '{kind: k, sample: smp, channel: ch, end_of_data: eod, channel_count: cc,
              sample_rate: rate, bits_per_sample: bits, error_code: code, last_result: 1'b0};
        step_words.push_back(w);
    endfunction

    function automatic bit tag_byte(logic [7:0] b);
        pr_tag = {pr_tag[23:0], b};
        pr_fcnt++;
        if (pr_fcnt >= 4) begin
            pr_fcnt = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit size_byte(logic [7:0] b);
        logic [31:0] k;
        k = pr_fcnt & 3;
        if (k == 0) pr_size = 0;
        pr_size |= 32'(b) << (8 * k);
        pr_fcnt = k + 1;
        if (pr_fcnt >= 4) begin
            pr_fcnt = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] bytes_per_sample();
        return (pr_ch == 0) ? 32'd0 : pr_ba / pr_ch;
    endfunction

    // Advance the predictor by one byte; leave its result words in step_words
    function automatic void predict_byte(logic [7:0] b, logic fin);
        t_err err;
        logic [31:0] off, sb, k, v;
        logic eod;
        err = E_NONE;
        step_words = {};
        case (pr_phase)
            PH_RIFF: if (tag_byte(b)) begin
                if (pr_tag == TAG_RIFF) pr_phase = PH_RSIZE; else err = E_NO_RIFF;
            end
            PH_RSIZE: if (size_byte(b)) pr_phase = PH_WAVE;
            PH_WAVE: if (tag_byte(b)) begin
                if (pr_tag == TAG_WAVE) pr_phase = PH_ID; else err = E_NO_WAVE;
            end
            PH_ID: if (tag_byte(b)) pr_phase = (pr_tag == TAG_FMT) ? PH_FSIZE : PH_SKSIZE;
            PH_SKSIZE: if (size_byte(b)) begin
                if (pr_size == 0) err = E_NO_FMT;
                else begin
                    pr_rem = pr_size;
                    pr_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (pr_rem > 0) pr_rem--;
                if (pr_rem == 0) pr_phase = PH_ID;
            end
            PH_FSIZE: if (size_byte(b)) begin
                if (pr_size != FMT_SIZE) err = E_FMT_SIZE;
                else begin
                    pr_rem = 16;
                    pr_phase = PH_FBODY;
                end
            end
            PH_FBODY: begin
                off = (32'd16 - (pr_rem & 32'd31)) & 32'd15;
                if (off < 2) pr_type |= 32'(b) << (8 * off);
                else if (off < 4) pr_ch |= 32'(b) << (8 * (off - 2));
                else if (off < 8) pr_rate |= 32'(b) << (8 * (off - 4));
                else if (off < 12) ;
                else if (off < 14) pr_ba |= 32'(b) << (8 * (off - 12));
                else pr_bits |= 32'(b) << (8 * (off - 14));
                if (pr_rem > 0) pr_rem--;
                if (pr_rem == 0) begin
                    sb = bytes_per_sample();
                    if (pr_type != 1) err = E_TYPE;
                    else if (pr_bits % 8 != 0) err = E_BITS;
                    else if (pr_ch < 1 || pr_ch > MAX_CHANNELS || sb < 1 ||
                             sb > MAX_SAMPLE_BYTES || pr_bits > 8 * MAX_SAMPLE_BYTES)
                        err = E_UNSUP;
                    else pr_phase = PH_DTAG;
                end
            end
            PH_DTAG: if (tag_byte(b)) begin
                if (pr_tag == TAG_DATA) pr_phase = PH_DSIZE; else err = E_NO_DATA;
            end
            PH_DSIZE: if (size_byte(b)) begin
                if (pr_size == 0) err = E_EMPTY;
                else begin
                    add_word(K_FORMAT, 0, 0, 0, pr_ch[1:0], pr_rate, pr_bits[5:0], E_NONE);
                    pr_rem = pr_size;
                    pr_left = 64'(pr_size / pr_ba) * 64'(pr_ch);
                    pr_asm = 0;
                    pr_sidx = 0;
                    pr_cur = 0;
                    pr_phase = (pr_left != 0) ? PH_SAMP : PH_DRAIN;
                end
            end
            PH_SAMP: begin
                sb = bytes_per_sample();
                k = pr_sidx & 3;
                pr_asm |= 32'(b) << (8 * k);
                if (pr_rem > 0) pr_rem--;
                if (k + 1 >= sb) begin
                    v = pr_asm << ((32 - 8 * sb) & 31);
                    if (sb == 1) v ^= 32'h8000_0000;
                    pr_left--;
                    eod = (pr_left == 0);
                    add_word(K_SAMPLE, v, pr_cur[0], eod, 0, 0, 0, E_NONE);
                    pr_asm = 0;
                    pr_sidx = 0;
                    pr_cur = (pr_cur + 1 < pr_ch) ? ((pr_cur + 1) & 1) : 0;
                    if (eod) pr_phase = (pr_rem != 0) ? PH_DRAIN : PH_DONE;
                end else begin
                    pr_sidx = k + 1;
                end
            end
            PH_DRAIN: begin
                if (pr_rem > 0) pr_rem--;
                if (pr_rem == 0) pr_phase = PH_DONE;
            end
            PH_DONE, PH_ERR: ;
            default: pr_phase = PH_ERR;
        endcase
        if (err != E_NONE) begin
            add_word(K_ERROR, 0, 0, 0, 0, 0, 0, err);
            pr_phase = PH_ERR;
        end
        if (fin) begin
            if (pr_phase != PH_DONE && pr_phase != PH_ERR)
                add_word(K_ERROR, 0, 0, 0, 0, 0, 0, E_TRUNC);
            parser_clear();
        end
        if (step_words.size() > 0) step_words[step_words.size() - 1].last_result = 1'b1;
    endfunction

    // Offer one byte; hold it until accepted, then queue its expected words
    task automatic send_byte(logic [7:0] b, logic fin, bit typed, t_err code);
        t_out_word w;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= '{byte_in: b, stream_end: fin};
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_byte(b, fin);
        if (typed) begin
            w = '0;
            w.kind = K_ERROR;
            w.error_code = code;
            w.last_result = 1'b1;
            expected_words.push_back(w);
        end else begin
            foreach (step_words[i]) expected_words.push_back(step_words[i]);
        end
        bytes_sent++;
        if (fin) files_sent++;
        @(negedge i_clk);
    endtask

    task automatic put_be32(logic [31:0] v);
        for (int i = 3; i >= 0; i--) wav_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic put_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++) wav_bytes.push_back(v[8*i +: 8]);
    endtask

    // Build one file: mostly well formed with random content, some broken or noise
    task automatic build_file();
        int nch, sb, ba, bits, dsize, nskip, sk;
        wav_bytes = {};
        if ($urandom_range(0, 14) == 0) begin
            repeat ($urandom_range(1, 12)) wav_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        put_be32(($urandom_range(0, 19) == 0) ? $urandom : TAG_RIFF);
        put_le($urandom, 4);
        put_be32(($urandom_range(0, 19) == 0) ? $urandom : TAG_WAVE);
        nskip = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        repeat (nskip) begin
            put_be32($urandom | 32'h0000_0001);
            sk = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 5);
            put_le(sk, 4);
            repeat (sk) wav_bytes.push_back(8'($urandom_range(0, 255)));
        end
        put_be32(TAG_FMT);
        put_le(($urandom_range(0, 14) == 0) ? $urandom_range(0, 40) : 16, 4);
        put_le(($urandom_range(0, 14) == 0) ? $urandom_range(0, 65535) : 1, 2);
        nch = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 4) : $urandom_range(1, 2);
        put_le(nch, 2);
        put_le($urandom, 4);
        put_le($urandom, 4);
        sb = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 4);
        ba = nch * sb + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
        if ($urandom_range(0, 29) == 0) ba = $urandom_range(0, 65535);
        put_le(ba, 2);
        bits = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 40) : 8 * sb;
        put_le(bits, 2);
        put_be32(($urandom_range(0, 19) == 0) ? $urandom : TAG_DATA);
        dsize = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 24);
        put_le(dsize, 4);
        repeat (dsize) wav_bytes.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) wav_bytes.push_back(8'($urandom_range(0, 255)));
        // cut the file short now and then
        if ($urandom_range(0, 7) == 0)
            wav_bytes = wav_bytes[0 : $urandom_range(0, wav_bytes.size() - 1)];
    endtask

    // Directed rows: tag errors, a file cut after one byte, end on an idle parser
    typedef struct {
        logic [7:0] b;
        logic       fin;
        bit         typed;
        t_err       code;
    } t_row;

    t_row directed_rows[] = '{
        '{8'h52, 0, 0, E_NONE}, '{8'h49, 0, 0, E_NONE}, '{8'h46, 0, 0, E_NONE},
        '{8'h58, 1, 1, E_NO_RIFF},
        '{8'h52, 1, 1, E_TRUNC},
        '{8'h00, 1, 1, E_TRUNC},
        '{8'hFF, 1, 1, E_TRUNC},
        '{8'h52, 0, 0, E_NONE}, '{8'h49, 0, 0, E_NONE}, '{8'h46, 0, 0, E_NONE},
        '{8'h46, 0, 0, E_NONE},
        '{8'hFF, 0, 0, E_NONE}, '{8'hFF, 0, 0, E_NONE}, '{8'h00, 0, 0, E_NONE},
        '{8'h00, 0, 0, E_NONE},
        '{8'h57, 0, 0, E_NONE}, '{8'h41, 0, 0, E_NONE}, '{8'h56, 0, 0, E_NONE},
        '{8'h00, 0, 1, E_NO_WAVE},
        '{8'hAA, 1, 0, E_NONE}
    };

    // Stimulus
    initial begin
        in_if.valid = 1'b0;
        in_if.data  = '0;
        parser_clear();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].fin, directed_rows[i].typed,
                      directed_rows[i].code);
        while (bytes_sent < 700) begin
            build_file();
            if (bytes_sent > 250 && bytes_sent < 320 && !long_hold) long_hold = 1'b1;
            if (bytes_sent > 600) idle_on = 1'b0;
            foreach (wav_bytes[i])
                send_byte(wav_bytes[i], i == wav_bytes.size() - 1, 0, E_NONE);
            // wait for the result queue to run dry between files mid-run
            if (bytes_sent > 450 && bytes_sent < 520) begin
                in_if.valid <= 1'b0;
                @(negedge i_clk);
                while (expected_words.size() != 0) @(negedge i_clk);
            end
        end
        in_if.valid <= 1'b0;
        for (int n = 0; n < 5000 && expected_words.size() != 0; n++) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        $display("%0d bytes in %0d files sent, %0d result words checked", bytes_sent,
                 files_sent, words_checked);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d words still expected", mismatches,
                     expected_words.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Result side: random stalls and long hold-offs
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                out_if.ready <= 1'b0;
                repeat (200) @(negedge i_clk);
                long_hold = 1'b0;
                out_if.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Compare each result word with the oldest expected one
    always @(posedge i_clk) begin
        t_out_word got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", got);
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (got.kind !== want.kind || got.sample !== want.sample ||
                    got.channel !== want.channel || got.end_of_data !== want.end_of_data ||
                    got.channel_count !== want.channel_count ||
                    got.sample_rate !== want.sample_rate ||
                    got.bits_per_sample !== want.bits_per_sample ||
                    got.error_code !== want.error_code ||
                    got.last_result !== want.last_result) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: exp %p got %p", want, got);
                end
            end
        end
    end

    // Hard limit on run length
    initial begin
        #2_000_000;
        $display("timeout with %0d words outstanding", expected_words.size());
        $display("end of test: mismatches");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/wsp_pkg.sv
hw/rtl/wsp_if.sv
hw/rtl/wsp_datapath.sv
hw/rtl/wsp_ctrl.sv
hw/rtl/wav_stream_parser_top.sv
dv/tb_wav_stream_parser_top.sv
